### src/si_window_tracker_defines.svh
// ----------------------------------------------------------------------------
// SI window tracker assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SI_WINDOW_TRACKER_DEFINES_SVH
`define SI_WINDOW_TRACKER_DEFINES_SVH

// Invariant that holds at every clock edge out of reset.
`define SWT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define SWT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/swt_pkg.sv
// ----------------------------------------------------------------------------
// SI window tracker package
// Types, widths and codes shared by the tracker modules and interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package swt_pkg;

  localparam int unsigned MaxMsgsDefault = 8;
  localparam int unsigned CntW    = 4;
  localparam int unsigned SlotW   = 28;
  localparam int unsigned XW      = 19;
  localparam int unsigned FramesW = 17;
  localparam int unsigned ProdW   = 25;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    OpTick     = 2'd0,
    OpActivate = 2'd1,
    OpTx       = 2'd2,
    OpStop     = 2'd3
  } swt_op_e;

  localparam logic [CfgIdxW-1:0] RegWinLen   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSpf      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPaging   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPeriods  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPos      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPosValid = 3'd5;
  localparam logic [CfgIdxW-1:0] RegActReq   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMsgCount = 3'd7;

  typedef struct packed {
    swt_op_e     op;
    logic [2:0]  msg_index;
    logic [27:0] abs_slot;
    logic [9:0]  frame_number;
    logic [7:0]  slot_in_frame;
    logic        segments_given;
    logic [6:0]  segment_count;
  } swt_in_t;

  typedef struct packed {
    logic [7:0]  pending_mask;
    logic [7:0]  open_mask;
    logic [7:0]  active_mask;
    logic [7:0]  missed_mask;
    logic [15:0] total_tx;
    logic        bad_index;
  } swt_out_t;

  typedef struct packed {
    logic [10:0] window_len_slots;
    logic [7:0]  slots_per_frame;
    logic [8:0]  paging_cycle_frames;
    logic [23:0] period_codes;
    logic [63:0] window_positions;
    logic [7:0]  position_valid_mask;
    logic [7:0]  activation_required_mask;
    logic [3:0]  message_count;
  } swt_cfg_t;

  typedef struct packed {
    logic [SlotW-1:0] deadline;
    logic [SlotW-1:0] win_end;
    logic [7:0]       win_tx;
    logic [15:0]      total;
  } swt_entry_t;

  typedef struct packed {
    logic          start;
    logic [XW-1:0] dividend;
    logic [7:0]    divisor;
  } swt_div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [XW-1:0] quot;
    logic [7:0]    rem;
  } swt_div_rsp_t;

endpackage

`default_nettype wire

### src/swt_in_if.sv
// ----------------------------------------------------------------------------
// SI window tracker input channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface swt_in_if;
  logic            valid;
  logic            ready;
  swt_pkg::swt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/swt_out_if.sv
// ----------------------------------------------------------------------------
// SI window tracker output channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface swt_out_if;
  logic              valid;
  logic              ready;
  swt_pkg::swt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/swt_divider.sv
// ----------------------------------------------------------------------------
// SI window tracker divider
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module swt_divider (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire swt_pkg::swt_div_req_t req_i,
  output swt_pkg::swt_div_rsp_t      rsp_o
);

  localparam int unsigned CntBits = $clog2(swt_pkg::XW + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntBits-1:0]     cnt_q, cnt_d;
  logic [swt_pkg::XW-1:0] quo_q, quo_d;
  logic [7:0]             rem_q, rem_d;
  logic [7:0]             div_q, div_d;
  logic [8:0]             trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[swt_pkg::XW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(swt_pkg::XW);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = 8'(trial - {1'b0, div_q});
        quo_d = {quo_q[swt_pkg::XW-2:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[swt_pkg::XW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

### src/swt_engine.sv
// ----------------------------------------------------------------------------
// SI window tracker engine
// Sequencer over the per-message memory: ticks, activations, reports, stops, results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "si_window_tracker_defines.svh"

module swt_engine #(
  parameter int unsigned MaxMsgs = swt_pkg::MaxMsgsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire swt_pkg::swt_cfg_t cfg_i,
  input  wire logic              init_i,
  input  wire logic              start_i,
  input  wire swt_pkg::swt_in_t  item_i,
  output logic                   idle_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output swt_pkg::swt_out_t      res_o
);

  localparam int unsigned AddrW = (MaxMsgs > 1) ? $clog2(MaxMsgs) : 1;

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StTickRd   = 4'd1;
  localparam logic [3:0] StTickEv   = 4'd2;
  localparam logic [3:0] StTickMul  = 4'd3;
  localparam logic [3:0] StTickDiv  = 4'd4;
  localparam logic [3:0] StTickWait = 4'd5;
  localparam logic [3:0] StTickChk  = 4'd6;
  localparam logic [3:0] StActRd    = 4'd7;
  localparam logic [3:0] StActEv    = 4'd8;
  localparam logic [3:0] StActMul   = 4'd9;
  localparam logic [3:0] StActWr    = 4'd10;
  localparam logic [3:0] StTxRd     = 4'd11;
  localparam logic [3:0] StTxEv     = 4'd12;
  localparam logic [3:0] StResRd    = 4'd13;
  localparam logic [3:0] StResEv    = 4'd14;
  localparam logic [3:0] StDone     = 4'd15;

  swt_pkg::swt_entry_t mem [MaxMsgs];
  swt_pkg::swt_entry_t rdata_q;
  swt_pkg::swt_entry_t ent_q, ent_d;
  swt_pkg::swt_entry_t wr_data;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [AddrW-1:0]    rd_addr;

  logic [3:0]                  state_q, state_d;
  swt_pkg::swt_in_t            item_q, item_d;
  logic [swt_pkg::CntW-1:0]    i_q, i_d;
  logic [MaxMsgs-1:0]          act_q, act_d;
  logic [MaxMsgs-1:0]          dval_q, dval_d;
  logic [MaxMsgs-1:0]          open_q, open_d;
  logic [MaxMsgs-1:0]          pend_q, pend_d;
  logic [MaxMsgs-1:0]          totv_q, totv_d;
  logic [MaxMsgs-1:0]          act_init;
  logic [7:0]                  missed_q, missed_d;
  logic [swt_pkg::XW-1:0]      x_q, x_d;
  logic [swt_pkg::FramesW-1:0] frames_q, frames_d;
  logic [swt_pkg::ProdW-1:0]   prod_q, prod_d;
  logic [15:0]                 total_q, total_d;

  swt_pkg::swt_div_req_t div_req;
  swt_pkg::swt_div_rsp_t div_rsp;

  logic [swt_pkg::CntW-1:0] cnt;
  logic [7:0]               nslots;
  logic                     bad;
  logic [7:0]               i_ext, idx_ext;
  logic [AddrW-1:0]         a_i, a_idx;
  logic [2:0]               i3, sel3;
  logic [2:0]               code;
  logic [7:0]               base;
  logic [10:0]              period;
  logic [9:0]               sfn_mod;
  logic                     last;
  logic                     do_init;
  logic [3:0]               shamt;

  assign cnt = (32'(cfg_i.message_count) > MaxMsgs) ? swt_pkg::CntW'(MaxMsgs) :
               (cfg_i.message_count > 4'd8) ? 4'd8 : cfg_i.message_count;
  assign nslots  = (cfg_i.slots_per_frame == 8'd0) ? 8'd1 : cfg_i.slots_per_frame;
  assign bad     = {1'b0, item_q.msg_index} >= cnt;
  assign i_ext   = {4'b0, i_q};
  assign idx_ext = {5'b0, item_q.msg_index};
  assign a_i     = i_ext[AddrW-1:0];
  assign a_idx   = idx_ext[AddrW-1:0];
  assign i3      = i_q[2:0];
  assign sel3    = (state_q == StActEv) ? item_q.msg_index : i3;
  assign code    = cfg_i.period_codes[3*sel3 +: 3];
  assign base    = cfg_i.position_valid_mask[i3] ? cfg_i.window_positions[8*i3 +: 8] : {5'b0, i3};
  assign period  = 11'd8 << code;
  assign sfn_mod = item_q.frame_number & 10'(period - 11'd1);
  assign last    = (i_q + 1'b1) == cnt;
  assign shamt   = 4'd3 + {1'b0, code};

  always_comb begin
    for (int b = 0; b < MaxMsgs; b++) begin
      act_init[b] = !((b < 8) && cfg_i.activation_required_mask[b % 8]);
    end
  end

  always_comb begin
    unique case (state_q)
      StTickRd: rd_addr = a_i;
      default:  rd_addr = a_idx;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    i_d      = i_q;
    act_d    = act_q;
    dval_d   = dval_q;
    open_d   = open_q;
    pend_d   = pend_q;
    totv_d   = totv_q;
    missed_d = missed_q;
    ent_d    = ent_q;
    x_d      = x_q;
    frames_d = frames_q;
    prod_d   = prod_q;
    total_d  = total_q;
    wr_en    = 1'b0;
    wr_addr  = a_i;
    wr_data  = ent_q;
    do_init  = init_i;
    div_req.start    = 1'b0;
    div_req.dividend = x_q;
    div_req.divisor  = nslots;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          item_d   = item_i;
          missed_d = '0;
          i_d      = '0;
          state_d  = StResRd;
          unique case (item_i.op)
            swt_pkg::OpTick:     if (cnt != '0) state_d = StTickRd;
            swt_pkg::OpActivate: state_d = StActRd;
            swt_pkg::OpTx:       state_d = StTxRd;
            swt_pkg::OpStop:     do_init = 1'b1;
          endcase
        end
      end
      StTickRd: state_d = StTickEv;
      StTickEv: begin
        ent_d   = rdata_q;
        state_d = last ? StResRd : StTickRd;
        i_d     = last ? i_q : i_q + 1'b1;
        if (open_q[a_i]) begin
          if (rdata_q.win_end <= item_q.abs_slot) begin
            missed_d[i3]   = (rdata_q.win_tx == 8'd0);
            open_d[a_i]    = 1'b0;
            pend_d[a_i]    = 1'b0;
            wr_en          = 1'b1;
            wr_data        = rdata_q;
            wr_data.win_tx = '0;
          end
        end else if (act_q[a_i]) begin
          if (dval_q[a_i] && (rdata_q.deadline <= item_q.abs_slot)) begin
            act_d[a_i] = 1'b0;
          end else begin
            state_d = StTickMul;
            i_d     = i_q;
          end
        end
      end
      StTickMul: begin
        x_d     = base * cfg_i.window_len_slots;
        state_d = StTickDiv;
      end
      StTickDiv: begin
        div_req.start = 1'b1;
        state_d       = StTickWait;
      end
      StTickWait: if (div_rsp.done) state_d = StTickChk;
      StTickChk: begin
        state_d = last ? StResRd : StTickRd;
        i_d     = last ? i_q : i_q + 1'b1;
        if ((item_q.slot_in_frame == div_rsp.rem) &&
            ({9'b0, sfn_mod} == div_rsp.quot)) begin
          open_d[a_i]     = 1'b1;
          pend_d[a_i]     = 1'b1;
          wr_en           = 1'b1;
          wr_data         = ent_q;
          wr_data.win_end = swt_pkg::SlotW'(item_q.abs_slot + {17'b0, cfg_i.window_len_slots});
          wr_data.win_tx  = '0;
        end
      end
      StActRd: state_d = bad ? StResRd : StActEv;
      StActEv: begin
        ent_d    = rdata_q;
        frames_d = {8'b0, cfg_i.paging_cycle_frames} +
                   (swt_pkg::FramesW'(item_q.segment_count) << shamt);
        state_d  = StActMul;
      end
      StActMul: begin
        prod_d  = frames_q * nslots;
        state_d = StActWr;
      end
      StActWr: begin
        act_d[a_idx]  = 1'b1;
        dval_d[a_idx] = item_q.segments_given;
        if (item_q.segments_given) begin
          wr_en            = 1'b1;
          wr_addr          = a_idx;
          wr_data          = ent_q;
          wr_data.deadline = swt_pkg::SlotW'(item_q.abs_slot + {3'b0, prod_q});
        end
        state_d = StResRd;
      end
      StTxRd: state_d = bad ? StResRd : StTxEv;
      StTxEv: begin
        if (open_q[a_idx]) begin
          wr_en   = 1'b1;
          wr_addr = a_idx;
          wr_data = rdata_q;
          if (rdata_q.win_tx != 8'hFF) wr_data.win_tx = rdata_q.win_tx + 1'b1;
          if (!totv_q[a_idx]) begin
            wr_data.total = 16'd1;
          end else if (rdata_q.total != 16'hFFFF) begin
            wr_data.total = rdata_q.total + 1'b1;
          end
          totv_d[a_idx] = 1'b1;
          pend_d[a_idx] = 1'b0;
        end
        state_d = StResRd;
      end
      StResRd: state_d = StResEv;
      StResEv: begin
        total_d = (!bad && totv_q[a_idx]) ? rdata_q.total : 16'd0;
        state_d = StDone;
      end
      StDone: if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase

    if (do_init) begin
      act_d  = act_init;
      dval_d = '0;
      open_d = '0;
      pend_d = '0;
      totv_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      act_q   <= '1;
      dval_q  <= '0;
      open_q  <= '0;
      pend_q  <= '0;
      totv_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      act_q   <= act_d;
      dval_q  <= dval_d;
      open_q  <= open_d;
      pend_q  <= pend_d;
      totv_q  <= totv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    missed_q <= missed_d;
    ent_q    <= ent_d;
    x_q      <= x_d;
    frames_q <= frames_d;
    prod_q   <= prod_d;
    total_q  <= total_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  swt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    res_o = '0;
    for (int b = 0; b < 8; b++) begin
      if ((b < MaxMsgs) && (4'(b) < cnt)) begin
        res_o.pending_mask[b] = pend_q[b % MaxMsgs];
        res_o.open_mask[b]    = open_q[b % MaxMsgs];
        res_o.active_mask[b]  = act_q[b % MaxMsgs];
      end
    end
    res_o.missed_mask = missed_q;
    res_o.total_tx    = total_q;
    res_o.bad_index   = bad;
  end

  assign idle_o      = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);

  `SWT_ASSERT(a_open_is_active, (open_q & ~act_q) == '0, "open window on inactive message")
  `SWT_ASSERT(a_pend_is_open, (pend_q & ~open_q) == '0, "pending message without open window")
  `SWT_ASSERT_IMP(a_bad_no_total, res_valid_o && res_o.bad_index, res_o.total_tx == 16'd0,
                  "total reported for bad index")
  `SWT_ASSERT_NEXT(a_div_start, state_q == StTickDiv, div_rsp.busy, "divider did not start")

endmodule

`default_nettype wire

### src/si_window_tracker.sv
// ----------------------------------------------------------------------------
// SI window tracker
// Tracks SI message windows, activations and transmission counts per slot.
// ----------------------------------------------------------------------------
// Requests arrive on in_i: a slot tick, an activation, a transmission report
// or a stop. Each request yields exactly one result transaction on out_o with
// the pending, open, active and missed masks and the total count of the
// addressed message. Configuration is written on cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write it only while the block is idle, which the block does
// not enforce. Every write reinitializes the message flags, and in_i is not
// ready in the cycle after a write. Per-message deadlines, window ends and
// counts live in one memory with a registered read. A tick visits each
// configured message in StTickRd and StTickEv; where the window start is
// tested, it also uses the 19-step serial divider in StTickMul to StTickChk.
// The next request is accepted once the engine is back in idle, even while a
// result waits in the output register; a stalled receiver holds the engine
// after that. Reset restores the default registers, sets every message active
// and clears the open, pending, deadline and total flags at once; no request
// is lost or repeated around a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module si_window_tracker #(
  parameter int unsigned MaxMsgs = swt_pkg::MaxMsgsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [swt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [swt_pkg::CfgW-1:0]     cfg_data_i,
  swt_in_if.sink                            in_i,
  swt_out_if.source                         out_o
);

  swt_pkg::swt_cfg_t cfg_q, cfg_d;
  logic              init_q;
  logic              eng_idle;
  logic              res_valid;
  logic              res_ready;
  swt_pkg::swt_out_t res;
  logic              out_valid_q;
  swt_pkg::swt_out_t out_data_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swt_pkg::RegWinLen:   cfg_d.window_len_slots         = cfg_data_i[10:0];
        swt_pkg::RegSpf:      cfg_d.slots_per_frame          = cfg_data_i[7:0];
        swt_pkg::RegPaging:   cfg_d.paging_cycle_frames      = cfg_data_i[8:0];
        swt_pkg::RegPeriods:  cfg_d.period_codes             = cfg_data_i[23:0];
        swt_pkg::RegPos:      cfg_d.window_positions         = cfg_data_i;
        swt_pkg::RegPosValid: cfg_d.position_valid_mask      = cfg_data_i[7:0];
        swt_pkg::RegActReq:   cfg_d.activation_required_mask = cfg_data_i[7:0];
        swt_pkg::RegMsgCount: cfg_d.message_count            = cfg_data_i[3:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len_slots         <= 11'd20;
      cfg_q.slots_per_frame          <= 8'd20;
      cfg_q.paging_cycle_frames      <= 9'd128;
      cfg_q.period_codes             <= '0;
      cfg_q.window_positions         <= '0;
      cfg_q.position_valid_mask      <= '0;
      cfg_q.activation_required_mask <= '0;
      cfg_q.message_count            <= '0;
      init_q                         <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      init_q <= cfg_we_i;
    end
  end

  assign in_i.ready = eng_idle && !init_q;
  assign res_ready  = !out_valid_q || out_o.ready;

  swt_engine #(
    .MaxMsgs (MaxMsgs)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .init_i      (init_q),
    .start_i     (in_i.valid && in_i.ready),
    .item_i      (in_i.data),
    .idle_o      (eng_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire
